>>> hw/rtl/etf_pkg.sv
`timescale 1ns / 1ps

package etf_pkg;

	localparam int FRAC_BITS = 28;
	localparam int IDX_CMP_W = 13;
	localparam logic [63:0] ESC_BOUND = 64'h0400_0000_0000_0000;

	typedef enum logic [2:0] {
		REG_ORIGIN_REAL = 3'd0,
		REG_ORIGIN_IMAG = 3'd1,
		REG_STEP_REAL   = 3'd2,
		REG_STEP_IMAG   = 3'd3,
		REG_CONST_REAL  = 3'd4,
		REG_CONST_IMAG  = 3'd5,
		REG_ITER_LIMIT  = 3'd6
	} reg_index_t;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_START_X = 9'b000000010,
		ST_START_Y = 9'b000000100,
		ST_START_I = 9'b000001000,
		ST_MUL_II  = 9'b000010000,
		ST_TEST    = 9'b000100000,
		ST_UPD_RE  = 9'b001000000,
		ST_UPD_IM  = 9'b010000000,
		ST_FINISH  = 9'b100000000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/escape_time_fractal_iter_core.sv
`timescale 1ns / 1ps

// Escape-time iteration of z -> z*z + c per pixel, signed Q4.28.
// Input channel: column/row with pixel_valid/pixel_stall; an item is taken
// when pixel_valid is high and pixel_stall low. pixel_stall stays high from
// acceptance until the result is placed in the output register.
// Output channel: iteration_count with count_valid/count_stall. The result
// register holds while count_stall is high; a new pixel is accepted while a
// finished result still waits there.
// Config: wr_en/wr_index/wr_data, to be written by the user only while
// idle; the block itself does not enforce it. The start point is formed
// in START_X, START_Y and START_I, the first squares and escape test in
// MUL_II and TEST; each iteration runs MUL_II, TEST, UPD_RE and UPD_IM on
// one shared 33x33 multiplier, and FINISH waits for the output register
// to drain. The next pixel is taken in IDLE after FINISH, never mid-item.
// Reset clears control state and loads the register defaults:
// origin -2-2i, step 2^-8, c = 0, limit 256.
module escape_time_fractal_iter_core
	import etf_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [9:0]  column,
	input  logic [9:0]  row,
	output logic        count_valid,
	input  logic        count_stall,
	output logic [15:0] iteration_count
);

	logic signed [31:0] origin_re_q, origin_im_q, const_re_q, const_im_q;
	logic [30:0] step_re_q, step_im_q;
	logic [15:0] limit_q;

	state_t state_q;
	logic [9:0] col_q, row_q;
	logic [15:0] stop_q, n_q;
	logic signed [31:0] re_q, im_q;
	logic signed [63:0] prod_q, sq_re_q, sq_im_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] product;
	logic [63:0] mag_sum;
	logic escape;
	logic out_valid_q;
	logic [15:0] out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= -32'sd536870912;
			origin_im_q <= -32'sd536870912;
			step_re_q <= 31'd1048576;
			step_im_q <= 31'd1048576;
			const_re_q <= '0;
			const_im_q <= '0;
			limit_q <= 16'd256;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_ORIGIN_REAL: origin_re_q <= wr_data;
				REG_ORIGIN_IMAG: origin_im_q <= wr_data;
				REG_STEP_REAL:   step_re_q <= wr_data[30:0];
				REG_STEP_IMAG:   step_im_q <= wr_data[30:0];
				REG_CONST_REAL:  const_re_q <= wr_data;
				REG_CONST_IMAG:  const_im_q <= wr_data;
				REG_ITER_LIMIT:  limit_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign pixel_stall = (state_q != ST_IDLE);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_START_X: begin
				mul_a = {2'b00, step_re_q};
				mul_b = {23'd0, col_q};
			end
			ST_START_Y: begin
				mul_a = {2'b00, step_im_q};
				mul_b = {23'd0, row_q};
			end
			ST_START_I, ST_UPD_IM: begin
				mul_a = 33'(re_q);
				mul_b = 33'(re_q);
			end
			ST_MUL_II: begin
				mul_a = 33'(im_q);
				mul_b = 33'(im_q);
			end
			// cross product stays in prod_q until the imaginary update
			ST_TEST, ST_UPD_RE: begin
				mul_a = 33'(re_q);
				mul_b = 33'(im_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	// squares are nonnegative and at most 2^62, so the sum fits unsigned 64 bits
	assign mag_sum = 64'(sq_re_q) + 64'(prod_q);
	assign escape = (n_q >= stop_q) || (mag_sum > ESC_BOUND);

	always_ff @(posedge clk) begin
		prod_q <= product[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && (!out_valid_q || !count_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !count_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pixel_valid) begin
						state_q <= ST_START_X;
					end
				end
				ST_START_X: state_q <= ST_START_Y;
				ST_START_Y: state_q <= ST_START_I;
				ST_START_I: state_q <= ST_MUL_II;
				ST_MUL_II:  state_q <= ST_TEST;
				ST_TEST: begin
					state_q <= escape ? ST_FINISH : ST_UPD_RE;
				end
				ST_UPD_RE: state_q <= ST_UPD_IM;
				ST_UPD_IM: state_q <= ST_MUL_II;
				ST_FINISH: begin
					if (!out_valid_q || !count_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if ({3'b000, column} >= IDX_CMP_W'(MAX_COLUMNS)) begin
					col_q <= 10'(MAX_COLUMNS - 1);
				end else begin
					col_q <= column;
				end
				if ({3'b000, row} >= IDX_CMP_W'(MAX_ROWS)) begin
					row_q <= 10'(MAX_ROWS - 1);
				end else begin
					row_q <= row;
				end
				stop_q <= (limit_q >= 16'd1) ? limit_q - 16'd1 : 16'd0;
				n_q <= '0;
			end
			ST_START_Y: re_q <= sat32(64'(origin_re_q) + prod_q);
			ST_START_I: im_q <= sat32(64'(origin_im_q) + prod_q);
			ST_MUL_II:  sq_re_q <= prod_q;
			ST_TEST:    sq_im_q <= prod_q;
			ST_UPD_RE: begin
				// arithmetic shift is the floor rounding
				re_q <= sat32(((sq_re_q - sq_im_q) >>> FRAC_BITS) + 64'(const_re_q));
			end
			ST_UPD_IM: begin
				im_q <= sat32((prod_q >>> (FRAC_BITS - 1)) + 64'(const_im_q));
				n_q <= n_q + 16'd1;
			end
			ST_FINISH: begin
				if (!out_valid_q || !count_stall) begin
					out_count_q <= n_q;
				end
			end
			default: ;
		endcase
	end

	assign count_valid = out_valid_q;
	assign iteration_count = out_count_q;

endmodule

>>> test/escape_time_fractal_iter_core_tb.sv
`timescale 1ns / 1ps

module escape_time_fractal_iter_core_tb
	import etf_pkg::*;
();

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int PHASES = 16;
	localparam int PIXELS_PER_PHASE = 110;
	localparam int HOLD_CYCLES = 400;
	localparam logic [63:0] RADIUS_SQ_Q56 = 64'h0400_0000_0000_0000;

	typedef struct {
		bit          is_wr;
		reg_index_t  idx;
		logic [31:0] data;
		logic [9:0]  col;
		logic [9:0]  rw;
		bit          typed;
		logic [15:0] want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = REG_ORIGIN_REAL;
	logic [31:0] wr_data = '0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [9:0]  column = '0;
	logic [9:0]  row = '0;
	logic        count_valid;
	logic        count_stall = 1'b0;
	logic [15:0] iteration_count;

	// shadow of the register file
	logic signed [31:0] cfg_origin_re = 32'shE000_0000;
	logic signed [31:0] cfg_origin_im = 32'shE000_0000;
	logic [30:0]        cfg_step_re = 31'd1048576;
	logic [30:0]        cfg_step_im = 31'd1048576;
	logic signed [31:0] cfg_c_re = '0;
	logic signed [31:0] cfg_c_im = '0;
	logic [15:0]        cfg_limit = 16'd256;

	logic [15:0] pending_counts[$];
	dir_row_t    dir_rows[$];
	logic [15:0] got_want;
	int errors = 0;
	int checked = 0;
	int max_seen = 0;
	int pixels_sent = 0;
	int settings_used = 1;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	escape_time_fractal_iter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.column(column),
		.row(row),
		.count_valid(count_valid),
		.count_stall(count_stall),
		.iteration_count(iteration_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_q428(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [15:0] escape_count(logic [9:0] col, logic [9:0] rw);
		longint re, im, sq_re, sq_im, cross_p;
		logic [63:0] ar, ai;
		int unsigned stop, n;
		re = clamp_q428(longint'(cfg_origin_re) + longint'(col) * longint'(cfg_step_re));
		im = clamp_q428(longint'(cfg_origin_im) + longint'(rw) * longint'(cfg_step_im));
		stop = (cfg_limit >= 16'd1) ? cfg_limit - 1 : 0;
		n = 0;
		while (n < stop) begin
			ar = (re < 0) ? -re : re;
			ai = (im < 0) ? -im : im;
			if (ar * ar + ai * ai > RADIUS_SQ_Q56)
				break;
			sq_re = re * re;
			sq_im = im * im;
			cross_p = re * im;
			// arithmetic shift floors, matching round toward minus infinity
			re = clamp_q428(((sq_re - sq_im) >>> FRAC_BITS) + longint'(cfg_c_re));
			im = clamp_q428((cross_p >>> (FRAC_BITS - 1)) + longint'(cfg_c_im));
			n++;
		end
		return n[15:0];
	endfunction

	// wait until every count is back and the block is idle
	task automatic settle();
		pixel_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] d);
		settle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		case (idx)
			REG_ORIGIN_REAL: cfg_origin_re = d;
			REG_ORIGIN_IMAG: cfg_origin_im = d;
			REG_STEP_REAL:   cfg_step_re = d[30:0];
			REG_STEP_IMAG:   cfg_step_im = d[30:0];
			REG_CONST_REAL:  cfg_c_re = d;
			REG_CONST_IMAG:  cfg_c_im = d;
			REG_ITER_LIMIT:  cfg_limit = d[15:0];
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer_pixel(logic [9:0] c, logic [9:0] r, bit typed, logic [15:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		column <= c;
		row <= r;
		do @(posedge clk); while (pixel_stall);
		pending_counts.push_back(typed ? want : escape_count(c, r));
		pixels_sent++;
	endtask

	function automatic void add_wr(reg_index_t idx, logic [31:0] d);
		dir_row_t e;
		e = '{1'b1, idx, d, 10'd0, 10'd0, 1'b0, 16'd0};
		dir_rows.push_back(e);
	endfunction

	function automatic void add_px(logic [9:0] c, logic [9:0] r, bit typed, logic [15:0] want);
		dir_row_t e;
		e = '{1'b0, REG_ORIGIN_REAL, 32'd0, c, r, typed, want};
		dir_rows.push_back(e);
	endfunction

	task automatic new_setting(int p);
		logic [31:0] v[7];
		if (p % 5 == 4) begin
			// raw bits: mostly far-out start points and wild constants
			for (int i = 0; i < 6; i++)
				v[i] = $urandom;
			v[REG_ITER_LIMIT] = $urandom_range(0, 80);
		end else begin
			v[REG_ORIGIN_REAL] = 32'hE000_0000 + $urandom_range(0, 32'h0800_0000);
			v[REG_ORIGIN_IMAG] = 32'hE000_0000 + $urandom_range(0, 32'h0800_0000);
			v[REG_STEP_REAL] = $urandom_range(32'h0004_0000, 32'h0020_0000);
			v[REG_STEP_IMAG] = $urandom_range(32'h0004_0000, 32'h0020_0000);
			v[REG_CONST_REAL] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			v[REG_CONST_IMAG] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			v[REG_ITER_LIMIT] = ($urandom_range(3) == 0) ? $urandom_range(65, 400)
				: $urandom_range(2, 64);
		end
		for (int i = 0; i < 7; i++)
			write_reg(reg_index_t'(i), v[i]);
		settings_used++;
	endtask

	// result side: random stall, plus one long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				count_stall <= 1'b1;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				count_stall <= 1'b1;
			end else begin
				count_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && count_valid && !count_stall) begin
			if (pending_counts.size() == 0) begin
				$error("iteration_count: expected none, got %0d", iteration_count);
				errors++;
			end else begin
				got_want = pending_counts.pop_front();
				if (iteration_count !== got_want) begin
					$error("iteration_count: expected %0d, got %0d", got_want, iteration_count);
					errors++;
				end
				checked++;
				if (int'(iteration_count) > max_seen)
					max_seen = int'(iteration_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		// reset defaults: origin -2-2i, step 2^-8, c = 0, limit 256
		add_px(10'd0, 10'd0, 1'b1, 16'd0);
		add_px(10'd512, 10'd512, 1'b1, 16'd255);   // z = 0 stays put
		add_px(10'd1023, 10'd1023, 1'b1, 16'd0);
		add_px(10'd512, 10'd0, 1'b1, 16'd1);       // |z| exactly 2
		add_px(10'd0, 10'd512, 1'b1, 16'd1);
		add_px(10'd700, 10'd300, 1'b0, 16'd0);
		add_px(10'd600, 10'd520, 1'b0, 16'd0);
		// tiny limits
		add_wr(REG_ITER_LIMIT, 32'd0);
		add_px(10'd512, 10'd512, 1'b1, 16'd0);
		add_wr(REG_ITER_LIMIT, 32'd1);
		add_px(10'd512, 10'd512, 1'b1, 16'd0);
		add_wr(REG_ITER_LIMIT, 32'd2);
		add_px(10'd512, 10'd512, 1'b1, 16'd1);
		// start point saturates high, then sits at the low bound
		add_wr(REG_ORIGIN_REAL, 32'h7FFF_FFFF);
		add_wr(REG_STEP_REAL, 32'hFFFF_FFFF);
		add_px(10'd1023, 10'd512, 1'b1, 16'd0);
		add_px(10'd0, 10'd512, 1'b1, 16'd0);
		add_wr(REG_ORIGIN_REAL, 32'h8000_0000);
		add_wr(REG_STEP_REAL, 32'd0);
		add_px(10'd1023, 10'd512, 1'b1, 16'd0);
		add_wr(REG_ORIGIN_REAL, 32'd0);
		add_wr(REG_ORIGIN_IMAG, 32'h8000_0000);
		add_wr(REG_STEP_IMAG, 32'hFFFF_FFFF);
		add_px(10'd5, 10'd1023, 1'b1, 16'd0);
		// extreme constants drive the iterate to its bounds
		add_wr(REG_ORIGIN_IMAG, 32'd0);
		add_wr(REG_STEP_IMAG, 32'd0);
		add_wr(REG_ITER_LIMIT, 32'd16);
		add_wr(REG_CONST_REAL, 32'h7FFF_FFFF);
		add_px(10'd0, 10'd0, 1'b1, 16'd1);
		add_wr(REG_CONST_REAL, 32'h8000_0000);
		add_px(10'd0, 10'd0, 1'b1, 16'd1);
		add_wr(REG_ORIGIN_REAL, 32'h2000_0000);
		add_wr(REG_CONST_REAL, 32'h7FFF_FFFF);
		add_px(10'd0, 10'd0, 1'b1, 16'd1);
		add_wr(REG_ORIGIN_REAL, 32'd0);
		add_wr(REG_CONST_REAL, 32'hF000_0000);
		add_wr(REG_CONST_IMAG, 32'h8000_0000);
		add_px(10'd0, 10'd0, 1'b1, 16'd1);
		// largest limit, point never escapes
		add_wr(REG_CONST_REAL, 32'd0);
		add_wr(REG_CONST_IMAG, 32'd0);
		add_wr(REG_ITER_LIMIT, 32'd65535);
		add_px(10'd0, 10'd0, 1'b1, 16'd65534);
		// negative products exercise the floor rounding
		add_wr(REG_ORIGIN_REAL, 32'hE800_0000);
		add_wr(REG_ORIGIN_IMAG, 32'hE800_0000);
		add_wr(REG_STEP_REAL, 32'h0010_0000);
		add_wr(REG_STEP_IMAG, 32'h0010_0000);
		add_wr(REG_CONST_REAL, 32'hF400_0000);
		add_wr(REG_CONST_IMAG, 32'h0199_999A);
		add_wr(REG_ITER_LIMIT, 32'd100);
		add_px(10'd384, 10'd384, 1'b0, 16'd0);
		add_px(10'd300, 10'd420, 1'b0, 16'd0);
		add_px(10'd100, 10'd700, 1'b0, 16'd0);
		add_px(10'd511, 10'd255, 1'b0, 16'd0);
		add_px(10'd0, 10'd1023, 1'b0, 16'd0);
		add_px(10'd1023, 10'd0, 1'b0, 16'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_wr)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				offer_pixel(dir_rows[i].col, dir_rows[i].rw, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			new_setting(p);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			// back up the result side while items keep coming
			if (p == 4)
				hold_req = 1'b1;
			for (int k = 0; k < PIXELS_PER_PHASE; k++)
				offer_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)),
					1'b0, 16'd0);
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Sent %0d pixels over %0d register settings, %0d counts checked",
			pixels_sent, settings_used, checked);
		$display("Longest count seen: %0d iterations", max_seen);
		if (errors == 0 && pending_counts.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/etf_pkg.sv
hw/rtl/escape_time_fractal_iter_core.sv
test/escape_time_fractal_iter_core_tb.sv
